// ===== hdl/mfpp_pkg.sv =====
// ----------------------------------------------------------------------------
// mfpp_pkg
// shared constants and codes for the monochrome frame store pixel plotter
// ----------------------------------------------------------------------------
package mfpp_pkg;

    localparam int STORE_BYTES = 4096;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 16;

    // item kinds
    localparam logic [1:0] KIND_DRAW = 2'd0;
    localparam logic [1:0] KIND_FILL = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_INDEX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_HEIGHT  = 3'd5;

    // rotation codes
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

endpackage

// ===== hdl/mono_framebuffer_pixel_plot.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_pixel_plot
// one-bit-per-pixel frame store with rotated pixel draw, fill and byte read
// ----------------------------------------------------------------------------
// draw: ST_MAP, ST_PAGE, ST_ADDR and ST_WRITE in turn, then ST_DONE loads the result
// read: ST_RDREQ addresses the store read port, ST_RDDATA takes its registered byte
// fill: one store byte written per cycle, every store byte swept for each beat
// a finished result waits in the output register while the next beat is taken
// after reset the store is swept to white, with s_tready low during the sweep
// configuration writes are taken in every cycle
module mono_framebuffer_pixel_plot
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mfpp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mfpp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // x_coord[15:0], y_coord[31:16], color_white[32], byte_index[48:33], zero[55:49]
    input  logic [mfpp_pkg::IN_DATA_W-1:0]      s_tdata,
    // kind[1:0]
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // read_byte[7:0], status[8], zero[15:9]
    output logic [mfpp_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import mfpp_pkg::*;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_MAP,
        ST_PAGE,
        ST_ADDR,
        ST_WRITE,
        ST_RDREQ,
        ST_RDDATA,
        ST_FILL,
        ST_DONE
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    logic [7:0]        mem [STORE_BYTES];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_we;

    state_t            state_reg, state_next;
    logic [9:0]        width_reg, width_next;
    logic [9:0]        height_reg, height_next;
    logic [1:0]        rot_reg, rot_next;
    logic              rev_reg, rev_next;
    logic [7:0]        pidx_reg, pidx_next;
    logic [9:0]        pht_reg, pht_next;

    logic signed [15:0] x_reg, x_next;
    logic signed [15:0] y_reg, y_next;
    logic              white_reg, white_next;
    logic [15:0]       bidx_reg, bidx_next;
    logic [9:0]        xm_reg, xm_next;
    logic [9:0]        ym_reg, ym_next;
    logic [9:0]        yp_reg, yp_next;
    logic [17:0]       base_reg, base_next;
    logic              clip_reg, clip_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [7:0]        fill_reg, fill_next;
    logic              report_reg, report_next;
    logic [7:0]        res_byte_reg, res_byte_next;
    logic              res_stat_reg, res_stat_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_stat_reg, out_stat_next;

    logic [9:0]        lw, lh, xl, yl, xm, ym;
    logic              clip_log;
    logic [18:0]       ydiff;
    logic              in_page;
    logic [16:0]       prod;
    logic [16:0]       idx_sum;
    logic [7:0]        mask;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'd0, out_stat_reg, out_byte_reg};

    // frame store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // logical clip and rotation
    always_comb
    begin
        lw = rot_reg[0] ? height_reg : width_reg;
        lh = rot_reg[0] ? width_reg : height_reg;
        xl = x_reg[9:0];
        yl = y_reg[9:0];
        clip_log = x_reg[15] || y_reg[15] ||
                   (x_reg[14:0] >= {5'd0, lw}) || (y_reg[14:0] >= {5'd0, lh});
        case (rot_reg)
            ROT_90:
            begin
                xm = width_reg - 10'd1 - yl;
                ym = xl;
            end
            ROT_180:
            begin
                xm = width_reg - 10'd1 - xl;
                ym = height_reg - 10'd1 - yl;
            end
            ROT_270:
            begin
                xm = yl;
                ym = height_reg - 10'd1 - xl;
            end
            default:
            begin
                xm = xl;
                ym = yl;
            end
        endcase
        if (rev_reg)
        begin
            ym = height_reg - 10'd1 - ym;
        end
    end

    // page window and byte address
    always_comb
    begin
        ydiff   = {9'd0, ym_reg} - {1'b0, base_reg};
        in_page = !ydiff[18] && (ydiff[17:0] < {8'd0, pht_reg});
        prod    = {7'd0, yp_reg} * {10'd0, width_reg[9:3]};
        idx_sum = prod + {10'd0, xm_reg[9:3]};
        mask    = 8'h80 >> xm_reg[2:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        rot_next       = rot_reg;
        rev_next       = rev_reg;
        pidx_next      = pidx_reg;
        pht_next       = pht_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        white_next     = white_reg;
        bidx_next      = bidx_reg;
        xm_next        = xm_reg;
        ym_next        = ym_reg;
        yp_next        = yp_reg;
        base_next      = base_reg;
        clip_next      = clip_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        report_next    = report_reg;
        res_byte_next  = res_byte_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_stat_next  = out_stat_reg;
        mem_raddr      = addr_reg;
        mem_waddr      = addr_reg;
        mem_wdata      = 8'h00;
        mem_we         = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PANEL_WIDTH:  width_next  = cfg_data;
                REG_PANEL_HEIGHT: height_next = cfg_data;
                REG_ROTATION:     rot_next    = cfg_data[1:0];
                REG_REVERSE_ROWS: rev_next    = cfg_data[0];
                REG_PAGE_INDEX:   pidx_next   = cfg_data[7:0];
                REG_PAGE_HEIGHT:  pht_next    = cfg_data;
                default:          ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_next        = s_tdata[15:0];
                    y_next        = s_tdata[31:16];
                    white_next    = s_tdata[32];
                    bidx_next     = s_tdata[48:33];
                    res_byte_next = 8'h00;
                    res_stat_next = 1'b0;
                    case (s_tuser)
                        KIND_DRAW: state_next = ST_MAP;
                        KIND_FILL:
                        begin
                            fill_next   = s_tdata[32] ? 8'h00 : 8'hFF;
                            cnt_next    = '0;
                            report_next = 1'b1;
                            state_next  = ST_FILL;
                        end
                        KIND_READ: state_next = ST_RDREQ;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_MAP:
            begin
                xm_next    = xm;
                ym_next    = ym;
                clip_next  = clip_log;
                base_next  = {10'd0, pidx_reg} * {8'd0, pht_reg};
                state_next = ST_PAGE;
            end
            ST_PAGE:
            begin
                if (xm_reg >= {width_reg[9:3], 3'b000})
                begin
                    clip_next = 1'b1;
                end
                if (pidx_reg != 8'd0)
                begin
                    yp_next = ydiff[9:0];
                    if (!in_page)
                    begin
                        clip_next = 1'b1;
                    end
                end
                else
                begin
                    yp_next = ym_reg;
                end
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                if ({15'd0, idx_sum} >= 32'(STORE_BYTES))
                begin
                    clip_next = 1'b1;
                end
                addr_next  = idx_sum[ADDR_W-1:0];
                mem_raddr  = idx_sum[ADDR_W-1:0];
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                mem_waddr     = addr_reg;
                mem_wdata     = white_reg ? (rd_data_reg & ~mask) : (rd_data_reg | mask);
                mem_we        = !clip_reg;
                res_stat_next = clip_reg;
                state_next    = ST_DONE;
            end
            ST_RDREQ:
            begin
                mem_raddr  = bidx_reg[ADDR_W-1:0];
                state_next = ST_RDDATA;
            end
            ST_RDDATA:
            begin
                if ({16'd0, bidx_reg} < 32'(STORE_BYTES))
                begin
                    res_byte_next = ~rd_data_reg;
                end
                else
                begin
                    res_byte_next = 8'hFF;
                end
                state_next = ST_DONE;
            end
            ST_FILL:
            begin
                mem_waddr = cnt_reg;
                mem_wdata = fill_reg;
                mem_we    = 1'b1;
                cnt_next  = cnt_reg + ADDR_W'(1);
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = report_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = res_byte_reg;
                    out_stat_next  = res_stat_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            width_reg     <= 10'd200;
            height_reg    <= 10'd200;
            rot_reg       <= 2'd0;
            rev_reg       <= 1'b0;
            pidx_reg      <= 8'd0;
            pht_reg       <= 10'd20;
            x_reg         <= '0;
            y_reg         <= '0;
            white_reg     <= 1'b0;
            bidx_reg      <= '0;
            xm_reg        <= '0;
            ym_reg        <= '0;
            yp_reg        <= '0;
            base_reg      <= '0;
            clip_reg      <= 1'b0;
            addr_reg      <= '0;
            cnt_reg       <= '0;
            fill_reg      <= 8'h00;
            report_reg    <= 1'b0;
            res_byte_reg  <= 8'h00;
            res_stat_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'h00;
            out_stat_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            rot_reg       <= rot_next;
            rev_reg       <= rev_next;
            pidx_reg      <= pidx_next;
            pht_reg       <= pht_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            white_reg     <= white_next;
            bidx_reg      <= bidx_next;
            xm_reg        <= xm_next;
            ym_reg        <= ym_next;
            yp_reg        <= yp_next;
            base_reg      <= base_next;
            clip_reg      <= clip_next;
            addr_reg      <= addr_next;
            cnt_reg       <= cnt_next;
            fill_reg      <= fill_next;
            report_reg    <= report_next;
            res_byte_reg  <= res_byte_next;
            res_stat_reg  <= res_stat_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_stat_reg  <= out_stat_next;
        end
    end

`ifndef SYNTHESIS
    // the store is only written by the sweep or by a draw that was not clipped
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_FILL) || (state_reg == ST_WRITE && !clip_reg))
        else $error("frame store written outside sweep or draw");

    // a clipped draw reports status and leaves the store alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && clip_reg) |-> !mem_we && res_stat_next)
        else $error("clipped draw wrote the store");

    // a result is only loaded from the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && !(out_valid_reg && !m_tready)) |-> (state_reg == ST_DONE))
        else $error("result loaded outside done state");

    // a sweep ends at the last store byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && state_next != ST_FILL) |-> (cnt_reg == LAST_ADDR))
        else $error("sweep left early");
`endif

endmodule
